### sv/adsr_enveloped_sine_generator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADSR enveloped sine generator
// Each macro places one labeled concurrent assertion on the clock, with the
// reset holding it off.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPED_SINE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPED_SINE_GENERATOR_MACROS_SVH

// Check that prop holds in the same cycle as cond
`define AESG_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Check that prop holds in the cycle after cond
`define AESG_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### sv/aesg_pkg.sv
// ----------------------------------------------------------------------------
// aesg_pkg
// Shared constants, types and helper functions of the ADSR enveloped sine
// generator: field widths, register indexes, stage codes and the sine table.
// ----------------------------------------------------------------------------
package aesg_pkg;

   // Quarter-wave sine table geometry
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_W           = 17;
   localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);

   // Fixed-point constants
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [16:0] ONE_Q16     = 17'h10000;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_TIME     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSTAIN_VALUE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_TIME   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_FREQUENCY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_OFFSET   = 3'd5;

   // Envelope stage codes
   typedef enum logic [1:0] {
      STAGE_ATTACK  = 2'd0,
      STAGE_DECAY   = 2'd1,
      STAGE_SUSTAIN = 2'd2,
      STAGE_RELEASE = 2'd3
   } stage_type;

   // Envelope durations handed to the envelope unit
   typedef struct packed {
      logic [15:0] attack_time;
      logic [15:0] decay_time;
      logic [15:0] sustain_value;
      logic [15:0] release_time;
   } env_cfg_type;

   // Envelope unit status and result
   typedef struct packed {
      logic        done;
      stage_type   stage;
      logic [16:0] env;
   } env_result_type;

   // Phase unit status and result: sine magnitude in Q0.16 and its sign
   typedef struct packed {
      logic              done;
      logic              neg;
      logic [SINE_W-1:0] mag;
   } sine_result_type;

   // Scale unit status and result
   typedef struct packed {
      logic        done;
      logic [15:0] sample;
   } scale_result_type;

   typedef logic [SINE_W-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   // Radix-4 partial product: digit times multiplicand
   function automatic logic [33:0] digit_multiple(input logic [1:0] digit,
                                                  input logic [31:0] mcand);
      logic [33:0] m1;
      logic [33:0] res;
      m1 = {2'b00, mcand};
      unique case (digit)
         2'd0:    res = '0;
         2'd1:    res = m1;
         2'd2:    res = m1 << 1;
         default: res = m1 + (m1 << 1);
      endcase
      return res;
   endfunction

   // Quarter-wave sine from an integer Taylor series in Q2.30, rounded to
   // Q0.16 and capped at one
   function automatic sine_table_type build_sine_table();
      sine_table_type     tbl;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         term = ((term * x2) >> 30) / 6;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 20;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 42;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 72;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 110;
         sum  = sum - $signed(term);
         term = ((term * x2) >> 30) / 156;
         sum  = sum + $signed(term);
         term = ((term * x2) >> 30) / 210;
         sum  = sum - $signed(term);
         if (sum < 0) begin
            sum = 64'sd0;
         end
         v = ($unsigned(sum) + 64'd8192) >> 14;
         if (v > 64'(ONE_Q16)) begin
            v = 64'(ONE_Q16);
         end
         tbl[k] = SINE_W'(v);
      end
      return tbl;
   endfunction

endpackage

### sv/adsr_enveloped_sine_generator.sv
// ----------------------------------------------------------------------------
// adsr_enveloped_sine_generator
// Turns each time stamp and energy beat into one ADSR-enveloped sine sample
// and its envelope stage.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_current_time, req_energy_level
//   rsp     | out       | rsp_valid/rsp_stall | rsp_sample, rsp_stage
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// One beat is worked at a time, from acceptance to the next acceptance: the
// envelope runs through the 17-step divider or is taken directly, after which
// the 9-step envelope multiply follows.
// Synchronous reset restores the register defaults and clears the time.
// A stalled result stays in the output register; the next beat is taken
// meanwhile and waits for that register to drain.
// ----------------------------------------------------------------------------
`include "adsr_enveloped_sine_generator_macros.svh"

module adsr_enveloped_sine_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_current_time,
   input  logic signed [15:0]                req_energy_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_sample,
   output logic [1:0]                        rsp_stage,
   input  logic                              csr_write_enable,
   input  logic [aesg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aesg_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   typedef enum logic [3:0] {
      TOP_IDLE  = 4'b0001,
      TOP_RUN   = 4'b0010,
      TOP_SCALE = 4'b0100,
      TOP_DRAIN = 4'b1000
   } top_state_type;

   top_state_type  state_ff, state_in;
   logic           start_ff;
   logic           env_got_ff, env_got_in;
   logic           ph_got_ff, ph_got_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    prev_time_ff;
   logic [31:0]    now_ff;
   logic [31:0]    delta_ff;
   logic [15:0]    energy_ff;
   logic [15:0]    rsp_sample_ff;
   logic [1:0]     rsp_stage_ff;

   logic [15:0]    attack_time_ff;
   logic [15:0]    decay_time_ff;
   logic [15:0]    sustain_value_ff;
   logic [15:0]    release_time_ff;
   logic [23:0]    tone_frequency_ff;
   logic [15:0]    phase_offset_ff;

   logic                       accept;
   logic                       both_ready;
   logic                       scale_start;
   logic                       out_free;
   logic                       out_load;
   aesg_pkg::env_cfg_type      env_cfg;
   aesg_pkg::env_result_type   env_res;
   aesg_pkg::sine_result_type  ph_res;
   aesg_pkg::scale_result_type scale_res;

   assign req_stall  = (state_ff != TOP_IDLE);
   assign accept     = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_stage  = rsp_stage_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_time_ff    <= 16'd13107;
         decay_time_ff     <= 16'd13107;
         sustain_value_ff  <= 16'd13107;
         release_time_ff   <= 16'd13107;
         tone_frequency_ff <= 24'd112640;
         phase_offset_ff   <= 16'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aesg_pkg::CSR_ATTACK_TIME:    attack_time_ff    <= csr_write_data[15:0];
            aesg_pkg::CSR_DECAY_TIME:     decay_time_ff     <= csr_write_data[15:0];
            aesg_pkg::CSR_SUSTAIN_VALUE:  sustain_value_ff  <= csr_write_data[15:0];
            aesg_pkg::CSR_RELEASE_TIME:   release_time_ff   <= csr_write_data[15:0];
            aesg_pkg::CSR_TONE_FREQUENCY: tone_frequency_ff <= csr_write_data;
            aesg_pkg::CSR_PHASE_OFFSET:   phase_offset_ff   <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign env_cfg = '{attack_time:   attack_time_ff,
                      decay_time:    decay_time_ff,
                      sustain_value: sustain_value_ff,
                      release_time:  release_time_ff};

   // Capture the beat and advance the stored time
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
      end else if (accept) begin
         prev_time_ff <= req_current_time;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff    <= req_current_time;
         delta_ff  <= req_current_time - prev_time_ff;
         energy_ff <= req_energy_level;
      end
   end

   aesg_env_unit u_env (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .delta  (delta_ff),
      .cfg    (env_cfg),
      .result (env_res)
   );

   aesg_phase_unit u_phase (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .now    (now_ff),
      .freq   (tone_frequency_ff),
      .phase  (phase_offset_ff),
      .result (ph_res)
   );

   aesg_scale_unit u_scale (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start),
      .energy (energy_ff),
      .env    (env_res.env),
      .sine   (ph_res),
      .result (scale_res)
   );

   // Sequence the beat through the units
   always_comb begin
      both_ready   = (env_got_ff || env_res.done) && (ph_got_ff || ph_res.done);
      out_free     = !rsp_valid_ff || !rsp_stall;
      scale_start  = 1'b0;
      out_load     = 1'b0;
      state_in     = state_ff;
      env_got_in   = env_got_ff || env_res.done;
      ph_got_in    = ph_got_ff || ph_res.done;
      unique case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               state_in = TOP_RUN;
            end
         end
         TOP_RUN: begin
            if (both_ready) begin
               scale_start = 1'b1;
               env_got_in  = 1'b0;
               ph_got_in   = 1'b0;
               state_in    = TOP_SCALE;
            end
         end
         TOP_SCALE: begin
            if (scale_res.done) begin
               state_in = TOP_DRAIN;
            end
         end
         TOP_DRAIN: begin
            // hold until the output register is free
            if (out_free) begin
               out_load = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         start_ff     <= 1'b0;
         env_got_ff   <= 1'b0;
         ph_got_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= accept;
         env_got_ff   <= env_got_in;
         ph_got_ff    <= ph_got_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= scale_res.sample;
         rsp_stage_ff  <= env_res.stage;
      end
   end

   `AESG_ASSERT_NXT(a_accept_starts_units, accept, start_ff, "accepted beat did not start the units")
   `AESG_ASSERT_IMP(a_scale_done_in_scale, scale_res.done, state_ff == TOP_SCALE, "scale result outside scale state")
   `AESG_ASSERT_IMP(a_sustain_level, env_res.done && env_res.stage == aesg_pkg::STAGE_SUSTAIN, env_res.env[15:0] == sustain_value_ff && !env_res.env[16], "sustain envelope differs from sustain level")
   `AESG_ASSERT_IMP(a_env_in_range, env_res.done, env_res.env <= aesg_pkg::ONE_Q16, "envelope above one")

endmodule

### sv/aesg_env_unit.sv
// ----------------------------------------------------------------------------
// aesg_env_unit
// Picks the envelope stage from the elapsed time and forms the Q0.16 envelope,
// directly or by a bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aesg_env_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              delta,
   input  aesg_pkg::env_cfg_type    cfg,
   output aesg_pkg::env_result_type result
);

   localparam int DIV_STEPS = 17;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ENV_IDLE   = 2'b01,
      ENV_DIVIDE = 2'b10
   } env_state_type;

   env_state_type       state_ff, state_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [15:0]         rem_ff, rem_in;
   logic [16:0]         nlow_ff, nlow_in;
   logic [15:0]         divisor_ff, divisor_in;
   logic [16:0]         addend_ff, addend_in;
   logic [16:0]         q_ff, q_in;
   aesg_pkg::stage_type stage_ff, stage_in;

   logic [16:0]         sum_ad;
   logic [17:0]         sum_ads;
   logic [15:0]         dt;
   logic [31:0]         rt;
   logic                rel_over;
   aesg_pkg::stage_type sel_stage;
   logic                sel_direct;
   logic [16:0]         sel_value;
   logic [15:0]         sel_num;
   logic [16:0]         sel_mul;
   logic [15:0]         sel_div;
   logic [16:0]         sel_addend;
   logic [32:0]         numer;
   logic [16:0]         trial;
   logic [16:0]         diff;
   logic                ge;

   // Pick the stage and the divide operands
   always_comb begin
      sum_ad     = {1'b0, cfg.attack_time} + {1'b0, cfg.decay_time};
      sum_ads    = {1'b0, sum_ad} + {2'b00, cfg.sustain_value};
      dt         = delta[15:0] - cfg.attack_time;
      rt         = delta - {14'd0, sum_ads};
      rel_over   = rt >= {16'd0, cfg.release_time};
      sel_stage  = aesg_pkg::STAGE_RELEASE;
      sel_direct = 1'b0;
      sel_value  = '0;
      sel_num    = cfg.release_time - rt[15:0];
      sel_mul    = aesg_pkg::ONE_Q16;
      sel_div    = cfg.release_time;
      sel_addend = '0;
      priority if (delta < {16'd0, cfg.attack_time}) begin
         sel_stage = aesg_pkg::STAGE_ATTACK;
         sel_num   = delta[15:0];
         sel_div   = cfg.attack_time;
      end else if (delta < {15'd0, sum_ad}) begin
         sel_stage  = aesg_pkg::STAGE_DECAY;
         sel_num    = cfg.decay_time - dt;
         sel_mul    = aesg_pkg::ONE_Q16 - {1'b0, cfg.sustain_value};
         sel_div    = cfg.decay_time;
         sel_addend = {1'b0, cfg.sustain_value};
      end else if (delta < {14'd0, sum_ads}) begin
         sel_stage  = aesg_pkg::STAGE_SUSTAIN;
         sel_direct = 1'b1;
         sel_value  = {1'b0, cfg.sustain_value};
      end else if (rel_over) begin
         // past the end of release; a zero release is full only at its start
         sel_direct = 1'b1;
         sel_value  = ((cfg.release_time == 16'd0) && (rt == 32'd0)) ?
                      aesg_pkg::ONE_Q16 : 17'd0;
      end
      numer = sel_num * sel_mul;
   end

   // One restoring divide step
   always_comb begin
      trial = {rem_ff, nlow_ff[16]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      state_in   = state_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      nlow_in    = nlow_ff;
      divisor_in = divisor_ff;
      addend_in  = addend_ff;
      q_in       = q_ff;
      stage_in   = stage_ff;
      unique case (state_ff)
         ENV_IDLE: begin
            if (start) begin
               stage_in = sel_stage;
               if (sel_direct) begin
                  q_in    = sel_value;
                  done_in = 1'b1;
               end else begin
                  // load the upper numerator into the remainder
                  rem_in     = numer[32:17];
                  nlow_in    = numer[16:0];
                  divisor_in = sel_div;
                  addend_in  = sel_addend;
                  count_in   = '0;
                  state_in   = ENV_DIVIDE;
               end
            end
         end
         ENV_DIVIDE: begin
            rem_in   = ge ? diff[15:0] : trial[15:0];
            nlow_in  = {nlow_ff[15:0], 1'b0};
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DIV_STEPS - 1)) begin
               // add the sustain floor on the last bit
               q_in     = {q_ff[15:0], ge} + addend_ff;
               done_in  = 1'b1;
               state_in = ENV_IDLE;
            end else begin
               q_in = {q_ff[15:0], ge};
            end
         end
         default: begin
            state_in = ENV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENV_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      nlow_ff    <= nlow_in;
      divisor_ff <= divisor_in;
      addend_ff  <= addend_in;
      q_ff       <= q_in;
      stage_ff   <= stage_in;
   end

   assign result.done  = done_ff;
   assign result.stage = stage_ff;
   assign result.env   = q_ff;

endmodule

### sv/aesg_phase_unit.sv
// ----------------------------------------------------------------------------
// aesg_phase_unit
// Forms the tone phase with a radix-4 digit-serial multiply of frequency and
// time, then reads the quarter-wave sine ROM and unfolds the quadrant.
// ----------------------------------------------------------------------------
module aesg_phase_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               now,
   input  logic [23:0]               freq,
   input  logic [15:0]               phase,
   output aesg_pkg::sine_result_type result
);

   localparam int PH_W      = 24;
   localparam int PH_FRAC_W = 22;
   localparam int PH_STEPS  = 12;
   localparam int CNT_W     = $clog2(PH_STEPS);
   localparam int PROD_W    = PH_FRAC_W + aesg_pkg::SINE_ADDR_W;
   localparam logic [aesg_pkg::SINE_ADDR_W-1:0] DEPTH_K =
      aesg_pkg::SINE_ADDR_W'(aesg_pkg::SINE_TABLE_DEPTH);
   localparam aesg_pkg::sine_table_type SINE_ROM = aesg_pkg::build_sine_table();

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_MUL    = 3'b010,
      PH_LOOKUP = 3'b100
   } ph_state_type;

   ph_state_type                  state_ff, state_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [PH_W-1:0]               acc_ff, acc_in;
   logic [PH_W-1:0]               mcand_ff, mcand_in;
   logic [PH_W-1:0]               now_sr_ff, now_sr_in;
   logic                          neg_ff;
   logic [aesg_pkg::SINE_W-1:0]   rom_ff;

   logic [PROD_W-1:0]             frac_prod;
   logic [aesg_pkg::SINE_IDX_W-1:0]  k_idx;
   logic [aesg_pkg::SINE_ADDR_W-1:0] rom_addr;

   // Fold the phase into a quarter-wave address
   always_comb begin
      frac_prod = {aesg_pkg::SINE_ADDR_W'(0), acc_ff[PH_FRAC_W-1:0]} * {
                   {PH_FRAC_W{1'b0}}, DEPTH_K};
      k_idx     = frac_prod[PH_FRAC_W +: aesg_pkg::SINE_IDX_W];
      rom_addr  = acc_ff[PH_W-2] ? (DEPTH_K - aesg_pkg::SINE_ADDR_W'(k_idx)) :
                                   aesg_pkg::SINE_ADDR_W'(k_idx);
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      now_sr_in = now_sr_ff;
      unique case (state_ff)
         PH_IDLE: begin
            if (start) begin
               acc_in    = {phase, 8'h00};
               mcand_in  = freq;
               now_sr_in = now[PH_W-1:0];
               count_in  = '0;
               state_in  = PH_MUL;
            end
         end
         PH_MUL: begin
            // accumulate two time bits a cycle, modulo one turn
            acc_in    = acc_ff + PH_W'(aesg_pkg::digit_multiple(now_sr_ff[1:0],
                                                                 32'(mcand_ff)));
            mcand_in  = mcand_ff << 2;
            now_sr_in = now_sr_ff >> 2;
            count_in  = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(PH_STEPS - 1)) begin
               state_in = PH_LOOKUP;
            end
         end
         PH_LOOKUP: begin
            done_in  = 1'b1;
            state_in = PH_IDLE;
         end
         default: begin
            state_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Read the ROM once the phase is complete
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      now_sr_ff <= now_sr_in;
      if (state_ff == PH_LOOKUP) begin
         rom_ff <= SINE_ROM[rom_addr];
         neg_ff <= acc_ff[PH_W-1];
      end
   end

   assign result.done = done_ff;
   assign result.neg  = neg_ff;
   assign result.mag  = rom_ff;

endmodule

### sv/aesg_scale_unit.sv
// ----------------------------------------------------------------------------
// aesg_scale_unit
// Scales energy times sine by the envelope with a radix-4 digit-serial
// multiply, then rounds half away from zero and saturates to Q8.8.
// ----------------------------------------------------------------------------
module aesg_scale_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [15:0]         energy,
   input  logic [16:0]                env,
   input  aesg_pkg::sine_result_type  sine,
   output aesg_pkg::scale_result_type result
);

   localparam int SC_STEPS = 9;
   localparam int CNT_W    = $clog2(SC_STEPS);
   localparam int ACC_W    = 48;

   typedef enum logic [2:0] {
      SC_IDLE  = 3'b001,
      SC_MUL   = 3'b010,
      SC_ROUND = 3'b100
   } sc_state_type;

   sc_state_type     state_ff, state_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      mcand_ff, mcand_in;
   logic [17:0]      env_sr_ff, env_sr_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [15:0]      sample_ff, sample_in;

   logic [15:0]      energy_mag;
   logic [32:0]      base_prod;
   logic [ACC_W-1:0] rnd;
   logic [15:0]      mag;
   logic [15:0]      sat;

   // Magnitude of energy times sine, and the rounded, saturated result
   always_comb begin
      energy_mag = energy[15] ? (~energy + 16'd1) : energy;
      base_prod  = energy_mag * sine.mag;
      rnd        = acc_ff + 48'h0000_8000_0000;
      mag        = rnd[47:32];
      if (neg_ff) begin
         sat = (mag > 16'd32768) ? 16'h8000 : (~mag + 16'd1);
      end else begin
         sat = (mag > 16'd32767) ? 16'h7fff : mag;
      end
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      env_sr_in = env_sr_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      sample_in = sample_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               mcand_in  = base_prod[31:0];
               env_sr_in = {1'b0, env};
               acc_in    = '0;
               neg_in    = energy[15] ^ sine.neg;
               count_in  = '0;
               state_in  = SC_MUL;
            end
         end
         SC_MUL: begin
            // shift in two envelope bits a cycle, most significant first
            acc_in    = (acc_ff << 2) +
                        ACC_W'(aesg_pkg::digit_multiple(env_sr_ff[17:16], mcand_ff));
            env_sr_in = env_sr_ff << 2;
            count_in  = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(SC_STEPS - 1)) begin
               state_in = SC_ROUND;
            end
         end
         SC_ROUND: begin
            sample_in = sat;
            done_in   = 1'b1;
            state_in  = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      env_sr_ff <= env_sr_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      sample_ff <= sample_in;
   end

   assign result.done   = done_ff;
   assign result.sample = sample_ff;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the ADSR enveloped sine generator
// Drives time stamp and energy beats through the request channel under
// random sender gaps and receiver stalls, predicts each sample and stage,
// and compares every result beat in order. Register settings change only
// while the block is idle and cover reset values, extremes, zero durations
// and random settings.
// ----------------------------------------------------------------------------
module tb;
   import aesg_pkg::*;

   localparam int unsigned     RUN_LIMIT       = 600000;
   localparam int unsigned     SETTLE_CYCLES   = 40;
   localparam int unsigned     HOLD_OFF_CYCLES = 300;
   localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
   localparam logic [23:0]     TONE_STEP_MAX   = 24'd11289600;

   // Indexes that select no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   // Register values after reset
   localparam logic [15:0] DURATION_RESET  = 16'd13107;
   localparam logic [23:0] TONE_STEP_RESET = 24'd112640;
   localparam logic [15:0] PHASE_RESET     = 16'd0;

   typedef struct {
      logic signed [15:0] sample;
      stage_type          stage;
   } tone_beat_t;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [31:0]            req_current_time = '0;
   logic signed [15:0]     req_energy_level = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic signed [15:0]     rsp_sample;
   logic [1:0]             rsp_stage;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // Predictor copy of the registers and the stored time
   logic [15:0]            env_attack;
   logic [15:0]            env_decay;
   logic [15:0]            env_sustain;
   logic [15:0]            env_release;
   logic [23:0]            tone_step;
   logic [15:0]            tone_phase;
   logic [31:0]            last_stamp;
   logic [16:0]            sine_rom [0:SINE_TABLE_DEPTH];

   tone_beat_t             pending_tones [$];
   int unsigned            mismatch_count   = 0;
   int unsigned            beats_checked    = 0;
   int unsigned            burst_left       = 0;
   logic [31:0]            stamp_cursor     = '0;
   logic                   hold_off_request = 1'b0;

   adsr_enveloped_sine_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_current_time (req_current_time),
      .req_energy_level (req_energy_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_stage        (rsp_stage),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Quarter-wave sine in Q0.16 from a Taylor series worked in Q2.30
   function automatic void fill_sine_rom();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint          sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = QUARTER_TURN_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ($unsigned(sum) + 64'd8192) >> 14;
         if (v > 64'd65536) begin
            v = 64'd65536;
         end
         sine_rom[k] = 17'(v);
      end
   endfunction

   function automatic void reset_tone_model();
      env_attack   = DURATION_RESET;
      env_decay    = DURATION_RESET;
      env_sustain  = DURATION_RESET;
      env_release  = DURATION_RESET;
      tone_step    = TONE_STEP_RESET;
      tone_phase   = PHASE_RESET;
      last_stamp   = '0;
      stamp_cursor = '0;
      fill_sine_rom();
   endfunction

   // Signed sine in Q0.16 at the phase reached by this time stamp
   function automatic longint sine_at(logic [31:0] stamp);
      logic [63:0]     acc;
      longint unsigned idx;
      longint unsigned quad;
      longint unsigned k;
      longint          v;
      acc  = 64'(tone_step) * 64'(stamp) + (64'(tone_phase) << 8);
      idx  = (64'(acc[23:0]) * 4 * 64'(SINE_TABLE_DEPTH)) >> 24;
      quad = idx / 64'(SINE_TABLE_DEPTH);
      k    = idx % 64'(SINE_TABLE_DEPTH);
      if (quad[0]) begin
         v = longint'(sine_rom[SINE_TABLE_DEPTH - k]);
      end else begin
         v = longint'(sine_rom[k]);
      end
      return quad[1] ? -v : v;
   endfunction

   // Envelope stage and level, then energy times envelope times sine
   function automatic tone_beat_t predict_tone_beat(logic [31:0] stamp,
                                                    logic signed [15:0] energy);
      tone_beat_t      beat;
      logic [31:0]     gap32;
      longint unsigned delta;
      longint unsigned a;
      longint unsigned d;
      longint unsigned s;
      longint unsigned r;
      longint unsigned rt;
      longint unsigned env;
      longint unsigned mag;
      longint          prod;
      gap32 = stamp - last_stamp;
      delta = gap32;
      a = env_attack;
      d = env_decay;
      s = env_sustain;
      r = env_release;
      if (delta < a) begin
         beat.stage = STAGE_ATTACK;
         env = (delta * 65536) / a;
      end else if (delta < a + d) begin
         beat.stage = STAGE_DECAY;
         env = s + ((d - (delta - a)) * (65536 - s)) / d;
      end else if (delta < a + d + s) begin
         beat.stage = STAGE_SUSTAIN;
         env = s;
      end else begin
         beat.stage = STAGE_RELEASE;
         rt = delta - a - d - s;
         if (r == 0) begin
            env = (rt == 0) ? 65536 : 0;
         end else if (rt >= r) begin
            env = 0;
         end else begin
            env = ((r - rt) * 65536) / r;
         end
      end
      prod = longint'(energy) * longint'(env) * sine_at(stamp);
      mag  = (prod < 0) ? $unsigned(-prod) : $unsigned(prod);
      mag  = (mag + 64'h8000_0000) >> 32;
      if (prod < 0) begin
         beat.sample = (mag > 32768) ? 16'sh8000 : 16'(-longint'(mag));
      end else begin
         beat.sample = (mag > 32767) ? 16'sh7FFF : 16'(mag);
      end
      last_stamp = stamp;
      return beat;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d, %s: got %0d, expected %0d",
               beats_checked, what, got, want);
      mismatch_count++;
   endtask

   // Compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin : check_tones
      tone_beat_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tones.size() == 0) begin
            report_mismatch("beat with none pending", rsp_sample, 0);
         end else begin
            want = pending_tones.pop_front();
            if (rsp_sample !== want.sample) begin
               report_mismatch("sample", rsp_sample, want.sample);
            end
            if (rsp_stage !== want.stage) begin
               report_mismatch("stage", rsp_stage, want.stage);
            end
         end
         beats_checked++;
      end
   end

   // Receiver stalls: stretches of no stall, light, heavy and sticky stall,
   // plus one long hold-off on request
   initial begin : rsp_stall_pattern
      int unsigned style;
      int unsigned stretch;
      int unsigned held;
      forever begin
         style   = $urandom_range(0, 3);
         stretch = $urandom_range(8, 150);
         repeat (stretch) begin
            @(negedge clock);
            if (hold_off_request) begin
               rsp_stall = 1'b1;
               held = 0;
               while (held < HOLD_OFF_CYCLES) begin
                  @(negedge clock);
                  held++;
               end
               hold_off_request = 1'b0;
            end
            case (style)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 3) == 0);
               2:       rsp_stall = ($urandom_range(0, 3) != 0);
               default: rsp_stall = ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
            endcase
         end
      end
   end

   // Bound the run
   initial begin : watchdog
      int unsigned cycles_run;
      cycles_run = 0;
      while (cycles_run < RUN_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one beat, with a random gap at the start of each burst
   task automatic send_beat(logic [31:0] stamp, logic signed [15:0] energy);
      int unsigned idle;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         idle = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 70)
                                            : $urandom_range(0, 4);
         if (idle > 0) begin
            req_valid = 1'b0;
            repeat (idle) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        = 1'b1;
      req_current_time = stamp;
      req_energy_level = energy;
      stamp_cursor     = stamp;
      do @(posedge clock); while (req_stall);
      pending_tones.push_back(predict_tone_beat(stamp, energy));
   endtask

   task automatic send_after(logic [31:0] delta, logic signed [15:0] energy);
      send_beat(stamp_cursor + delta, energy);
   endtask

   // Drop valid, wait for every predicted beat, then let the pipe empty
   task automatic settle_block();
      @(negedge clock);
      req_valid  = 1'b0;
      burst_left = 0;
      while (pending_tones.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_register(logic [CSR_IDX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      case (idx)
         CSR_ATTACK_TIME:    env_attack  = value[15:0];
         CSR_DECAY_TIME:     env_decay   = value[15:0];
         CSR_SUSTAIN_VALUE:  env_sustain = value[15:0];
         CSR_RELEASE_TIME:   env_release = value[15:0];
         CSR_TONE_FREQUENCY: tone_step   = value;
         CSR_PHASE_OFFSET:   tone_phase  = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Random junk in the unused upper bits of a 16-bit register write
   function automatic logic [CSR_DATA_W-1:0] pad16(logic [15:0] v);
      return {8'($urandom), v};
   endfunction

   task automatic set_durations(logic [15:0] a, logic [15:0] d,
                                logic [15:0] s, logic [15:0] r);
      program_register(CSR_ATTACK_TIME, pad16(a));
      program_register(CSR_DECAY_TIME, pad16(d));
      program_register(CSR_SUSTAIN_VALUE, pad16(s));
      program_register(CSR_RELEASE_TIME, pad16(r));
   endtask

   function automatic logic signed [15:0] random_energy();
      case ($urandom_range(0, 15))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Time step aimed at one envelope stage, a stage edge, or anywhere
   function automatic logic [31:0] aim_delta(int unsigned zone);
      longint unsigned a;
      longint unsigned d;
      longint unsigned s;
      longint unsigned r;
      longint unsigned base;
      longint unsigned span;
      logic [2:0]      pick;
      a = env_attack;
      d = env_decay;
      s = env_sustain;
      r = env_release;
      case (zone)
         0: begin base = 0;         span = a;       end
         1: begin base = a;         span = d;       end
         2: begin base = a + d;     span = s;       end
         3: begin base = a + d + s; span = r + 1;   end
         4: begin base = a + d + s + r; span = 64'd1 << 20; end
         5: begin
            pick = $urandom_range(0, 7);
            case (pick[2:1])
               2'd0:    base = a;
               2'd1:    base = a + d;
               2'd2:    base = a + d + s;
               default: base = a + d + s + r;
            endcase
            if (pick[0] && base != 0) begin
               base = base - 1;
            end
            return 32'(base);
         end
         default: return $urandom;
      endcase
      if (span == 0) begin
         return 32'(base);
      end
      return 32'(base + $urandom_range(0, 32'(span - 1)));
   endfunction

   task automatic run_random_beats(int unsigned count);
      repeat (count) begin
         send_after(aim_delta($urandom_range(0, 6)), random_energy());
      end
   endtask

   function automatic logic [15:0] pick_duration(bit compact);
      if (compact) begin
         return $urandom_range(0, 40);
      end
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return $urandom_range(1, 64);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic apply_random_settings(bit compact);
      logic [23:0] step;
      set_durations(pick_duration(compact), pick_duration(compact),
                    pick_duration(compact), pick_duration(compact));
      step = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                         : 24'($urandom_range(0, TONE_STEP_MAX));
      program_register(CSR_TONE_FREQUENCY, step);
      program_register(CSR_PHASE_OFFSET, pad16(16'($urandom)));
   endtask

   // Walk every stage edge at reset settings, then wrap time both ways
   task automatic test_stage_walk();
      logic [31:0] a;
      logic [31:0] ad;
      logic [31:0] ads;
      logic [31:0] adsr;
      a    = env_attack;
      ad   = a + env_decay;
      ads  = ad + env_sustain;
      adsr = ads + env_release;
      send_after(32'd0, 16'sh7FFF);
      send_after(a - 1, 16'sh8000);
      send_after(a, 16'sh0100);
      send_after(ad - 1, 16'shFFFF);
      send_after(ad, 16'sh0001);
      send_after(ads - 1, 16'sh4000);
      send_after(ads, 16'shC000);
      send_after(adsr - 1, 16'sh7FFF);
      send_after(adsr, 16'sh7FFF);
      send_after(32'hFFFF_FFFF, 16'sh0000);
      send_beat(32'hFFFF_FFFF, 16'sh8000);
      send_beat(32'h0000_0000, 16'sh2AAA);
      settle_block();
   endtask

   // Full-scale sine at full envelope: both signs, both saturation limits
   task automatic test_sign_saturation();
      program_register(CSR_TONE_FREQUENCY, 24'd0);
      program_register(CSR_PHASE_OFFSET, pad16(16'hC000));
      send_after(env_attack, 16'sh8000);
      send_after(env_attack, 16'sh7FFF);
      settle_block();
      program_register(CSR_PHASE_OFFSET, pad16(16'h4000));
      send_after(env_attack, 16'sh8000);
      send_after(env_attack, 16'sh7FFF);
      settle_block();
   endtask

   // Zero durations: skipped attack and decay, zero-length release
   task automatic test_zero_durations();
      set_durations(16'd0, 16'd0, 16'd0, 16'd0);
      send_after(32'd0, 16'sh7FFF);
      send_after(32'd1, 16'sh7FFF);
      settle_block();
      set_durations(16'd0, 16'd100, 16'd100, 16'd100);
      send_after(32'd0, 16'sh7FFF);
      send_after(32'd50, 16'sh8000);
      settle_block();
      set_durations(16'd100, 16'd0, 16'd100, 16'd100);
      send_after(32'd100, 16'sh7FFF);
      send_after(32'd99, 16'sh7FFF);
      settle_block();
   endtask

   // Register extremes, frequency above range and writes to spare indexes
   task automatic test_register_extremes();
      set_durations(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      program_register(CSR_TONE_FREQUENCY, TONE_STEP_MAX);
      program_register(CSR_PHASE_OFFSET, pad16(16'hFFFF));
      run_random_beats(12);
      settle_block();
      set_durations(16'd1, 16'd1, 16'd1, 16'd1);
      program_register(CSR_TONE_FREQUENCY, 24'hFF_FFFF);
      program_register(CSR_PHASE_OFFSET, pad16(16'h0000));
      run_random_beats(12);
      settle_block();
      set_durations(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
      program_register(CSR_TONE_FREQUENCY, 24'd0);
      program_register(CSR_SPARE_6, 24'($urandom));
      program_register(CSR_SPARE_7, 24'($urandom));
      run_random_beats(12);
      settle_block();
   endtask

   // Hold off the receiver while the sender keeps offering beats
   task automatic test_backpressure();
      apply_random_settings(1'b0);
      hold_off_request = 1'b1;
      burst_left = 16;
      run_random_beats(16);
      settle_block();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 7; phase++) begin
         apply_random_settings(phase == 2 || phase == 5);
         run_random_beats(100);
         settle_block();
      end
   endtask

   initial begin : run_tests
      reset = 1'b1;
      reset_tone_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_stage_walk();
      test_sign_saturation();
      test_zero_durations();
      test_register_extremes();
      test_backpressure();
      test_random_phases();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/aesg_pkg.sv
sv/aesg_env_unit.sv
sv/aesg_phase_unit.sv
sv/aesg_scale_unit.sv
sv/adsr_enveloped_sine_generator.sv
bench/tb.sv
